// ===== rtl/core/urdr_pkg.sv =====
// shared types, sizes and codes for the uart receive descriptor ring unit
// no dependencies; imported by every module of the block
package urdr_pkg;

  localparam int SLOTS        = 8;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int CHANNELS     = 2;
  localparam int RING_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int BUFFER_BYTES = 1024;

  localparam int LEN_W   = 11;
  localparam int OFF_W   = 12;
  localparam int SIZE_W  = 11;
  localparam int SPACE_W = 11;
  localparam int LIMIT_W = 10;

  localparam logic [SIZE_W-1:0]  SIZE_MAX   = '1;
  localparam logic [SPACE_W-1:0] SPACE_FULL = SPACE_W'(BUFFER_BYTES);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = LIMIT_W;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [1:0] {
    REQ_RECORD  = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_CLEAR   = 2'd2,
    REQ_START   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_RECEIVING = 2'd1,
    MODE_WAIT      = 2'd2,
    MODE_GOT_DATA  = 2'd3
  } rx_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_CH0 = 2'd0,
    CFG_MAP_CH1 = 2'd1,
    CFG_REWIND  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic               map_ch0;
    logic               map_ch1;
    logic [LIMIT_W-1:0] rewind_limit;
  } cfg_t;

  typedef struct packed {
    logic load;  // latch the incoming request
    logic rd;    // read the descriptor under the selected pointer
    logic exec;  // apply the request and load the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } dp_stat_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] p);
    return (p >= SLOT_W'(SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [RING_W-1:0] ring_of(input logic [RING_W-1:0] c);
    return RING_W'(32'(c) % CHANNELS);
  endfunction

endpackage

// ===== rtl/core/uart_rx_descriptor_ring_unit.sv =====
// top level of the uart receive descriptor ring unit: config registers,
// sequencer and datapath; depends on urdr_pkg, urdr_ctrl and urdr_dp
//
// Each uart channel owns a ring of descriptors (buffer offset, message size;
// size zero means free) plus a receive pointer, a transmit pointer, a buffer
// write offset, the remaining space and a receive mode. A request comes in as
// one transfer on the slave stream and always yields exactly one result
// transfer on the master stream. Record stores the burst at the receive
// pointer if that slot is free (else the channel goes to wait), release
// reports and optionally frees the head slot of the own or mapped ring and
// wakes a waiting channel, clear resets a channel's ring and counters, start
// marks it receiving. A request passes from its input transfer to its result
// through the latch step, the registered descriptor read and the execute
// step, which updates state and loads the result register once that
// register is free. The request port reopens when the result is loaded,
// so requests never overlap; a stalled result holds back only the execute
// step of the request behind it. Descriptor state clears at reset through
// per-slot valid bits, so no clearing pass is needed. Configuration writes
// are taken at any edge with cfg_we_i high and must only happen while no
// request is in flight.
module uart_rx_descriptor_ring_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration write port
  input  logic                                   cfg_we_i,
  input  logic [urdr_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [urdr_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  // request stream
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // [0] channel, [11:1] length, [12] add_terminator, [13] update_ring,
  // [14] use_mapped_ring, [15] zero
  input  logic [urdr_pkg::IN_DATA_W-1:0]         s_axis_tdata_i,
  // [1:0] req_type
  input  logic [1:0]                             s_axis_tuser_i,
  // result stream
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // [0] accepted, [3:1] slot, [15:4] entry_offset, [26:16] entry_size,
  // [27] terminator_written, [39:28] terminator_offset, [41:40] receive_state,
  // [52:42] remaining_space, [64:53] next_write_offset, [71:65] zero
  output logic [urdr_pkg::OUT_DATA_W-1:0]        m_axis_tdata_o
);
  import urdr_pkg::*;

  cfg_t      cfg_q;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // config registers, writes to unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.map_ch0      <= 1'b0;
      cfg_q.map_ch1      <= 1'b1;
      cfg_q.rewind_limit <= LIMIT_W'(768);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAP_CH0: cfg_q.map_ch0      <= cfg_wdata_i[0];
        CFG_MAP_CH1: cfg_q.map_ch1      <= cfg_wdata_i[0];
        CFG_REWIND:  cfg_q.rewind_limit <= cfg_wdata_i;
        default:     cfg_q              <= cfg_q;
      endcase
    end
  end

  urdr_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .stat_i          (stat),
    .cmd_o           (cmd)
  );

  urdr_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // one request at a time: an input transfer closes the request port
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request port open while a request is in flight");

  // remaining space never exceeds the buffer
  a_space_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[52:42] <= SPACE_FULL)
    else $error("remaining space above buffer size");

  // a terminator is only requested by a stored record
  a_term_only_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[27] |-> m_axis_tdata_o[0])
    else $error("terminator without stored record");

  // the execute step only loads a result when the register is free
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |-> !m_axis_tvalid_o || m_axis_tready_i)
    else $error("result overwritten before transfer");

endmodule

// ===== rtl/core/urdr_ctrl.sv =====
// request sequencer: accept, descriptor read, execute
// depends on urdr_pkg
module urdr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  urdr_pkg::dp_stat_t  stat_i,
  output urdr_pkg::ctrl_cmd_t cmd_o
);
  import urdr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i && ready_q) begin
            state_q <= ST_READ;
            ready_q <= 1'b0;
          end
        end
        ST_READ: state_q <= ST_EXEC;
        ST_EXEC: begin
          if (stat_i.out_free) begin
            state_q <= ST_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign s_axis_tready_o = ready_q;

  always_comb begin
    cmd_o      = '0;
    cmd_o.load = (state_q == ST_IDLE) && s_axis_tvalid_i && ready_q;
    cmd_o.rd   = (state_q == ST_READ);
    cmd_o.exec = (state_q == ST_EXEC) && stat_i.out_free;
  end

endmodule

// ===== rtl/core/urdr_dp.sv =====
// descriptor rings, per-channel receive state and result register
// depends on urdr_pkg
module urdr_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  urdr_pkg::cfg_t                      cfg_i,
  input  urdr_pkg::ctrl_cmd_t                 cmd_i,
  output urdr_pkg::dp_stat_t                  stat_o,
  input  logic [1:0]                          s_axis_tuser_i,
  input  logic [urdr_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [urdr_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o
);
  import urdr_pkg::*;

  // latched request
  req_e              req_q;
  logic [RING_W-1:0] ch_q;
  logic [LEN_W-1:0]  len_q;
  logic              term_q;
  logic              upd_q;
  logic              mapped_q;

  // per-channel state
  logic [SLOT_W-1:0]  rx_ptr_q [CHANNELS];
  logic [SLOT_W-1:0]  tx_ptr_q [CHANNELS];
  logic [OFF_W-1:0]   wr_off_q [CHANNELS];
  logic [SPACE_W-1:0] space_q  [CHANNELS];
  rx_mode_e           mode_q   [CHANNELS];

  // descriptor store with valid bits; invalid reads as zero
  logic [OFF_W-1:0]  off_mem  [CHANNELS][SLOTS];
  logic [SIZE_W-1:0] size_mem [CHANNELS][SLOTS];
  logic              off_vld_q  [CHANNELS][SLOTS];
  logic              size_vld_q [CHANNELS][SLOTS];

  // read stage
  logic [RING_W-1:0] ring_d, ring_q;
  logic [SLOT_W-1:0] ptr_d, ptr_q;
  logic [OFF_W-1:0]  rd_off_q;
  logic [SIZE_W-1:0] rd_size_q;

  // result register
  logic                  out_vld_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic [RING_W-1:0] ch_in;
  assign ch_in = ring_of(RING_W'(s_axis_tdata_i[0]));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q    <= req_e'(s_axis_tuser_i);
      ch_q     <= ch_in;
      len_q    <= s_axis_tdata_i[11:1];
      term_q   <= s_axis_tdata_i[12];
      upd_q    <= s_axis_tdata_i[13];
      mapped_q <= s_axis_tdata_i[14];
    end
  end

  // ring and pointer selection for the descriptor read
  always_comb begin
    ring_d = ch_q;
    if (req_q == REQ_RELEASE && mapped_q) begin
      if (ch_q == RING_W'(0)) begin
        ring_d = ring_of(RING_W'(cfg_i.map_ch0));
      end else if (ch_q == RING_W'(1)) begin
        ring_d = ring_of(RING_W'(cfg_i.map_ch1));
      end
    end
    ptr_d = (req_q == REQ_RELEASE) ? tx_ptr_q[ring_d] : rx_ptr_q[ring_d];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      ring_q    <= ring_d;
      ptr_q     <= ptr_d;
      rd_off_q  <= off_vld_q[ring_d][ptr_d] ? off_mem[ring_d][ptr_d] : '0;
      rd_size_q <= size_vld_q[ring_d][ptr_d] ? size_mem[ring_d][ptr_d] : '0;
    end
  end

  // record arithmetic
  logic              slot_free;
  logic [OFF_W:0]    wo_end;
  logic [OFF_W-1:0]  term_off;
  logic [OFF_W-1:0]  off_st;
  logic [LEN_W:0]    used;
  logic [SIZE_W-1:0] size_st;
  logic              rewind;
  logic [SPACE_W-1:0] space_sub;

  always_comb begin
    slot_free = (rd_size_q == '0);
    term_off  = OFF_W'({1'b0, wr_off_q[ch_q]} + (OFF_W + 1)'(len_q));
    wo_end    = {1'b0, wr_off_q[ch_q]} + (OFF_W + 1)'(len_q) + (OFF_W + 1)'(term_q);
    off_st    = wr_off_q[ch_q] + OFF_W'(term_q);
    used      = (LEN_W + 1)'(len_q) + (LEN_W + 1)'(term_q);
    size_st   = (used > (LEN_W + 1)'(SIZE_MAX)) ? SIZE_MAX : used[SIZE_W-1:0];
    rewind    = wo_end > (OFF_W + 1)'(cfg_i.rewind_limit);
    space_sub = ((LEN_W + 1)'(space_q[ch_q]) > used) ?
                SPACE_W'((LEN_W + 1)'(space_q[ch_q]) - used) : '0;
  end

  // next per-channel values for the requesting channel
  logic [SLOT_W-1:0]  rx_ptr_nx;
  logic [SLOT_W-1:0]  tx_ptr_nx;
  logic [OFF_W-1:0]   wr_off_nx;
  logic [SPACE_W-1:0] space_nx;
  rx_mode_e           mode_nx;
  logic               wr_desc;
  logic               clr_head;
  logic               clr_ring;

  always_comb begin
    rx_ptr_nx = rx_ptr_q[ch_q];
    tx_ptr_nx = tx_ptr_q[ch_q];
    wr_off_nx = wr_off_q[ch_q];
    space_nx  = space_q[ch_q];
    mode_nx   = mode_q[ch_q];
    wr_desc   = 1'b0;
    clr_head  = 1'b0;
    clr_ring  = 1'b0;
    case (req_q)
      REQ_RECORD: begin
        if (slot_free) begin
          wr_desc   = 1'b1;
          rx_ptr_nx = next_slot(ptr_q);
          wr_off_nx = rewind ? '0 : wo_end[OFF_W-1:0];
          space_nx  = rewind ? SPACE_FULL : space_sub;
          mode_nx   = MODE_IDLE;
        end else begin
          mode_nx = MODE_WAIT;
        end
      end
      REQ_RELEASE: begin
        clr_head = upd_q;
        if (mode_q[ch_q] == MODE_WAIT) begin
          mode_nx = MODE_GOT_DATA;
        end
      end
      REQ_CLEAR: begin
        clr_ring  = 1'b1;
        rx_ptr_nx = '0;
        tx_ptr_nx = '0;
        wr_off_nx = '0;
        space_nx  = SPACE_FULL;
      end
      REQ_START: mode_nx = MODE_RECEIVING;
      default: mode_nx = mode_q[ch_q];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        rx_ptr_q[c] <= '0;
        tx_ptr_q[c] <= '0;
        wr_off_q[c] <= '0;
        space_q[c]  <= SPACE_FULL;
        mode_q[c]   <= MODE_IDLE;
        for (int s = 0; s < SLOTS; s++) begin
          off_vld_q[c][s]  <= 1'b0;
          size_vld_q[c][s] <= 1'b0;
        end
      end
    end else if (cmd_i.exec) begin
      rx_ptr_q[ch_q] <= rx_ptr_nx;
      wr_off_q[ch_q] <= wr_off_nx;
      space_q[ch_q]  <= space_nx;
      mode_q[ch_q]   <= mode_nx;
      if (clr_ring) begin
        tx_ptr_q[ch_q] <= tx_ptr_nx;
        for (int s = 0; s < SLOTS; s++) begin
          size_vld_q[ch_q][s] <= 1'b0;
        end
      end
      if (clr_head) begin
        // release advances the head of the selected ring, not the requester's
        tx_ptr_q[ring_q]          <= next_slot(ptr_q);
        size_vld_q[ring_q][ptr_q] <= 1'b0;
      end
      if (wr_desc) begin
        off_vld_q[ring_q][ptr_q]  <= 1'b1;
        size_vld_q[ring_q][ptr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_desc) begin
      off_mem[ring_q][ptr_q]  <= off_st;
      size_mem[ring_q][ptr_q] <= size_st;
    end
  end

  // result assembly
  logic              acc_r;
  logic [SLOT_W-1:0] slot_r;
  logic [OFF_W-1:0]  eoff_r;
  logic [SIZE_W-1:0] esize_r;
  logic              tw_r;
  logic [OFF_W-1:0]  toff_r;

  always_comb begin
    acc_r   = 1'b0;
    slot_r  = '0;
    eoff_r  = '0;
    esize_r = '0;
    tw_r    = 1'b0;
    toff_r  = '0;
    case (req_q)
      REQ_RECORD: begin
        slot_r = ptr_q;
        if (slot_free) begin
          acc_r   = 1'b1;
          eoff_r  = off_st;
          esize_r = size_st;
          tw_r    = term_q;
          toff_r  = term_q ? term_off : '0;
        end else begin
          eoff_r  = rd_off_q;
          esize_r = rd_size_q;
        end
      end
      REQ_RELEASE: begin
        slot_r  = ptr_q;
        eoff_r  = rd_off_q;
        esize_r = rd_size_q;
      end
      default: acc_r = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_data_q <= {7'd0, wr_off_nx, space_nx, mode_nx, toff_r, tw_r,
                     esize_r, eoff_r, SLOT_W'(slot_r), acc_r};
    end
  end

  assign stat_o.out_free = !out_vld_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
